/* design/huffman_table_encoder_bit_packer_defines.svh */
// Assertion macros shared by the Huffman table encoder and bit packer.
// Include this header by its bare name; it depends on nothing else.
`ifndef HUFFMAN_TABLE_ENCODER_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTEBP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("htebp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTEBP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("htebp assertion failed");

`endif

/* design/htebp_pkg.sv */
// Shared types, constants and helper functions for the Huffman table encoder.
// Used by the front end, the operation queue, the packer and the top level.
`timescale 1ns / 1ps

package htebp_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_CODE_LEN = 32;
    localparam int WORD_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int CMD_W        = 2;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + WORD_W;
    localparam int NSUM_W       = 6;
    localparam int LEFT_W       = 3;
    localparam int TOTAL_W      = 32;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    localparam logic [CNT_W-1:0] FULL_BYTE_COUNT = 4'd8;

    typedef enum logic [1:0] {
        OP_ENCODE  = 2'd0,
        OP_UNKNOWN = 2'd1,
        OP_FLUSH   = 2'd2
    } op_kind_t;

    // Table entry: code bits already reversed so the first code bit is bit 0,
    // and masked to the code length.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] bits;
    } table_entry_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] bits;
    } op_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [CNT_W-1:0]   valid_bits;
        logic               last;
        logic               unknown;
        logic [TOTAL_W-1:0] total;
    } result_t;

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [WORD_W:0] m;
        m = ((WORD_W+1)'(1) << len) - (WORD_W+1)'(1);
        return m[WORD_W-1:0];
    endfunction

endpackage

/* design/htebp_front.sv */
// Front end: accepts commands, owns the code table and classifies each item.
// Depends on htebp_pkg; feeds classified operations into htebp_queue.
`timescale 1ns / 1ps

module htebp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [htebp_pkg::CMD_W-1:0]         command,
    input  logic [htebp_pkg::SYM_W-1:0]         symbol,
    input  logic [htebp_pkg::WORD_W-1:0]        code_word,
    input  logic [htebp_pkg::LEN_W-1:0]         code_length,
    output logic                                op_valid,
    input  logic                                op_ready,
    output htebp_pkg::op_t                      op_data
);

    htebp_pkg::table_entry_t code_mem [htebp_pkg::TABLE_DEPTH];
    htebp_pkg::table_entry_t rd_entry_reg;
    logic [htebp_pkg::TABLE_DEPTH-1:0] entry_valid_reg;

    logic                     s1_valid_reg;
    htebp_pkg::op_kind_t      s1_kind_reg;
    htebp_pkg::op_kind_t      s1_kind_next;

    logic                            accept;
    logic                            in_range;
    logic                            hit;
    logic [htebp_pkg::IDX_W-1:0]     idx;
    logic [htebp_pkg::LEN_W-1:0]     len_sat;
    htebp_pkg::table_entry_t         load_entry;

    assign in_ready = !s1_valid_reg || op_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(symbol) < htebp_pkg::TABLE_DEPTH);
    assign idx      = symbol[htebp_pkg::IDX_W-1:0];
    assign hit      = in_range && entry_valid_reg[idx];

    assign len_sat = (code_length > htebp_pkg::LEN_W'(htebp_pkg::MAX_CODE_LEN))
                   ? htebp_pkg::LEN_W'(htebp_pkg::MAX_CODE_LEN) : code_length;
    assign load_entry.len  = len_sat;
    assign load_entry.bits = htebp_pkg::bit_reverse(code_word) & htebp_pkg::low_mask(len_sat);

    always_comb begin
        if (command == htebp_pkg::CMD_FLUSH) begin
            s1_kind_next = htebp_pkg::OP_FLUSH;
        end else if (hit) begin
            s1_kind_next = htebp_pkg::OP_ENCODE;
        end else begin
            s1_kind_next = htebp_pkg::OP_UNKNOWN;
        end
    end

    // Table storage: written by loads, read on every accepted item.
    always_ff @(posedge aclk) begin
        if (accept && command == htebp_pkg::CMD_LOAD && in_range) begin
            code_mem[idx] <= load_entry;
        end
        if (accept) begin
            rd_entry_reg <= code_mem[idx];
            s1_kind_reg  <= s1_kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (accept && command == htebp_pkg::CMD_LOAD && in_range) begin
                entry_valid_reg[idx] <= 1'b1;
            end
            if (in_ready) begin
                s1_valid_reg <= accept && (command == htebp_pkg::CMD_ENCODE
                                           || command == htebp_pkg::CMD_FLUSH);
            end
        end
    end

    assign op_valid     = s1_valid_reg;
    assign op_data.kind = s1_kind_reg;
    assign op_data.len  = rd_entry_reg.len;
    assign op_data.bits = rd_entry_reg.bits;

endmodule

/* design/htebp_queue.sv */
// Short queue of classified operations between the front end and the packer.
// Depends on htebp_pkg for the operation type and the queue depth.
`timescale 1ns / 1ps

module htebp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  htebp_pkg::op_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output htebp_pkg::op_t pop_data
);

    htebp_pkg::op_t entries [htebp_pkg::QUEUE_DEPTH];

    logic [htebp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [htebp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [htebp_pkg::QCNT_W-1:0] count_reg;
    logic [htebp_pkg::QCNT_W-1:0] count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != htebp_pkg::QCNT_W'(htebp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/htebp_packer.sv */
// Back end: appends code bits to the pending bits; emits one byte per cycle while
// its output is free. Depends on htebp_pkg; takes operations from htebp_queue.
`timescale 1ns / 1ps

module htebp_packer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_valid,
    output logic              op_ready,
    input  htebp_pkg::op_t    op_data,
    output logic              res_valid,
    input  logic              res_ready,
    output htebp_pkg::result_t res_data
);

    logic [htebp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [htebp_pkg::PCNT_W-1:0]  pend_n_reg, pend_n_next;
    logic [htebp_pkg::LEFT_W-1:0]  left_reg, left_next;
    logic [htebp_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                          res_valid_reg, res_valid_next;
    htebp_pkg::result_t            res_reg, res_next;

    logic                          out_free;
    logic [htebp_pkg::ACC_W-1:0]   acc_new;
    logic [htebp_pkg::NSUM_W-1:0]  n_sum;
    logic [htebp_pkg::LEFT_W-1:0]  nbytes;
    logic [htebp_pkg::TOTAL_W:0]   total_sum;
    logic [htebp_pkg::TOTAL_W-1:0] total_new;

    assign out_free = !res_valid_reg || res_ready;

    assign acc_new = htebp_pkg::ACC_W'(acc_reg[htebp_pkg::PEND_W-1:0])
                   | (htebp_pkg::ACC_W'(op_data.bits) << pend_n_reg);
    assign n_sum   = htebp_pkg::NSUM_W'(pend_n_reg) + op_data.len;
    assign nbytes  = n_sum[htebp_pkg::NSUM_W-1:3];

    assign total_sum = {1'b0, total_reg} + (htebp_pkg::TOTAL_W+1)'(op_data.len);
    assign total_new = total_sum[htebp_pkg::TOTAL_W] ? '1 : total_sum[htebp_pkg::TOTAL_W-1:0];

    always_comb begin
        acc_next       = acc_reg;
        pend_n_next    = pend_n_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        op_ready       = 1'b0;

        if (left_reg != '0) begin
            // Draining the bytes of the current code.
            if (out_free) begin
                res_valid_next      = 1'b1;
                res_next.data_byte  = acc_reg[htebp_pkg::BYTE_W-1:0];
                res_next.valid_bits = htebp_pkg::FULL_BYTE_COUNT;
                res_next.last       = (left_reg == htebp_pkg::LEFT_W'(1));
                res_next.unknown    = 1'b0;
                res_next.total      = total_reg;
                acc_next            = acc_reg >> htebp_pkg::BYTE_W;
                left_next           = left_reg - 1'b1;
            end
        end else if (op_valid) begin
            case (op_data.kind)
                htebp_pkg::OP_ENCODE: begin
                    op_ready    = 1'b1;
                    total_next  = total_new;
                    pend_n_next = n_sum[htebp_pkg::PCNT_W-1:0];
                    if (nbytes != '0 && out_free) begin
                        res_valid_next      = 1'b1;
                        res_next.data_byte  = acc_new[htebp_pkg::BYTE_W-1:0];
                        res_next.valid_bits = htebp_pkg::FULL_BYTE_COUNT;
                        res_next.last       = (nbytes == htebp_pkg::LEFT_W'(1));
                        res_next.unknown    = 1'b0;
                        res_next.total      = total_new;
                        acc_next            = acc_new >> htebp_pkg::BYTE_W;
                        left_next           = nbytes - 1'b1;
                    end else begin
                        acc_next  = acc_new;
                        left_next = nbytes;
                    end
                end
                htebp_pkg::OP_UNKNOWN: begin
                    if (out_free) begin
                        op_ready            = 1'b1;
                        res_valid_next      = 1'b1;
                        res_next.data_byte  = '0;
                        res_next.valid_bits = '0;
                        res_next.last       = 1'b1;
                        res_next.unknown    = 1'b1;
                        res_next.total      = total_reg;
                    end
                end
                htebp_pkg::OP_FLUSH: begin
                    if (out_free) begin
                        op_ready            = 1'b1;
                        res_valid_next      = 1'b1;
                        res_next.data_byte  = htebp_pkg::BYTE_W'(acc_reg[htebp_pkg::PEND_W-1:0]);
                        res_next.valid_bits = htebp_pkg::CNT_W'(pend_n_reg);
                        res_next.last       = 1'b1;
                        res_next.unknown    = 1'b0;
                        res_next.total      = total_reg;
                        acc_next            = '0;
                        pend_n_next         = '0;
                    end
                end
                default: begin
                    op_ready = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (!aresetn) begin
            acc_reg       <= '0;
            pend_n_reg    <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            pend_n_reg    <= pend_n_next;
            left_reg      <= left_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

/* design/huffman_table_encoder_bit_packer.sv */
// Huffman table encoder with bit packer: top level of the block.
// Instantiates htebp_front, htebp_queue and htebp_packer; uses htebp_pkg.
//
// Usage: commands arrive on the s_ channel, one transfer per command. A load
// writes one code table entry and gives no result. An encode looks up a byte
// and appends its code bits; each byte that becomes full leaves on the m_
// channel as one transfer, the final one of the run marked by m_tlast. An
// encode of a symbol with no valid entry gives a single transfer with m_tuser
// high. A flush gives one transfer holding the partial byte and its bit count.
// Throughput: the packer emits one byte per cycle while the output register is
// free, so an encode occupies it until its output bytes (up to four) are out;
// unknown and flush results each give one transfer. The front end takes a command
// every cycle while its four-entry queue has room.
// The first result of a command passes through the table read register, the
// queue and the output register on its way out.
// Reset clears every table valid mark at once, the pending bits, the bit
// total and all handshake state; the block is ready as soon as reset is released.
// A stalled receiver holds the output register; the queue absorbs commands
// until full and then s_tready drops.
`timescale 1ns / 1ps
`include "huffman_table_encoder_bit_packer_defines.svh"

module huffman_table_encoder_bit_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: command[1:0], symbol[9:2], code_word[41:10], code_length[47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: out_byte[7:0], out_bit_count[11:8], total_bits[43:12], zero[47:44]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    // m_tuser: unknown_symbol
    output logic        m_tuser
);

    logic               fe_op_valid;
    logic               fe_op_ready;
    htebp_pkg::op_t     fe_op_data;
    logic               q_op_valid;
    logic               q_op_ready;
    htebp_pkg::op_t     q_op_data;
    htebp_pkg::result_t result;

    // Front end: table lookup and classification of every command.
    htebp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .command     (s_tdata[1:0]),
        .symbol      (s_tdata[9:2]),
        .code_word   (s_tdata[41:10]),
        .code_length (s_tdata[47:42]),
        .op_valid    (fe_op_valid),
        .op_ready    (fe_op_ready),
        .op_data     (fe_op_data)
    );

    // Decouples lookup from packing so either side can stall alone.
    htebp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_op_valid),
        .push_ready (fe_op_ready),
        .push_data  (fe_op_data),
        .pop_valid  (q_op_valid),
        .pop_ready  (q_op_ready),
        .pop_data   (q_op_data)
    );

    // Back end: bit accumulation, byte emission and the running bit total.
    htebp_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (q_op_valid),
        .op_ready  (q_op_ready),
        .op_data   (q_op_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (result)
    );

    assign m_tdata = {4'b0000, result.total, result.valid_bits, result.data_byte};
    assign m_tlast = result.last;
    assign m_tuser = result.unknown;

    // An unknown-symbol result carries no bits and closes its run.
    `HTEBP_ASSERT_IMPL(a_unknown_empty, aclk, aresetn, m_tvalid && m_tuser, m_tdata[11:0] == 12'd0 && m_tlast)

    // Every result that is not the last of its run is a full byte.
    `HTEBP_ASSERT_IMPL(a_inner_full, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[11:8] == 4'd8 && !m_tuser)

    // The running bit total never falls from one delivered result to the next.
    `HTEBP_ASSERT_NEXT(a_total_mono, aclk, aresetn, m_tvalid && m_tready, !m_tvalid || m_tdata[43:12] >= $past(m_tdata[43:12]))

endmodule

/* sim/huffman_table_encoder_bit_packer_test.sv */
// Self-checking testbench for the Huffman table encoder and bit packer.
// Depends only on htebp_pkg and the huffman_table_encoder_bit_packer RTL.
`timescale 1ns / 1ps

module huffman_table_encoder_bit_packer_test;
    import htebp_pkg::*;

    // The command code that the block must ignore has no name in the package.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_CYCLES      = 120;  // receiver hold-off in the backpressure phase
    localparam int QUIET_LIMIT      = 3000; // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES     = 12;   // idle cycles at the end for any stray output to show
    localparam int RANDOM_PER_PHASE = 40;
    localparam int MAX_PRINTED      = 40;   // mismatches beyond this are counted silently

    // Idling modes, one per phase of the run.
    typedef enum int {
        PH_FREE,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH_GAPS,
        PH_BACKPRESSURE
    } idle_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata, low bit up: command, symbol, code_word, code_length
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata, low bit up: out_byte, out_bit_count, total_bits, zero pad
    logic [47:0] m_tdata;
    logic        m_tlast;
    // m_tuser: unknown_symbol
    logic        m_tuser;

    idle_mode_t idle_mode  = PH_FREE;
    idle_mode_t ready_mode = PH_FREE;
    int         hold_left  = 0;
    bit         s_taken    = 1'b0;

    // Commands waiting to be offered, and output bytes the packer still owes.
    logic [47:0] cmd_backlog [$];
    result_t     bytes_due [$];

    // Symbols that the stimulus has loaded so far, for well-formed encodes.
    int          loaded_syms [$];
    bit [255:0]  loaded_mask = '0;

    // Shadow of the block's state, updated on every accepted command.
    bit                 code_valid [TABLE_DEPTH];
    logic [LEN_W-1:0]   shadow_len [TABLE_DEPTH];
    logic [WORD_W-1:0]  code_bits  [TABLE_DEPTH];
    logic [PEND_W-1:0]  pend_bits = '0;
    logic [PCNT_W-1:0]  pend_cnt  = '0;
    logic [TOTAL_W-1:0] bits_sent = '0;

    int mismatches     = 0;
    int n_in           = 0;
    int n_out          = 0;
    int n_unknown      = 0;
    int n_flush        = 0;
    int n_backpressure = 0;
    int quiet          = 0;

    huffman_table_encoder_bit_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Works out the output bytes that one accepted command causes and appends
    // them to bytes_due, updating the shadow table and bit accumulator.
    task automatic pack_command(input logic [47:0] word_in);
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [WORD_W-1:0] cw;
        logic [LEN_W-1:0]  clen;
        logic [38:0]       acc;
        logic [32:0]       sum;
        int                n;
        int                nbytes;
        int                i;
        result_t           r;
        cmd  = word_in[1:0];
        sym  = word_in[9:2];
        cw   = word_in[41:10];
        clen = word_in[47:42];
        r.last    = 1'b1;
        r.unknown = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                // A load marks the entry valid even with length zero.
                code_valid[sym] = 1'b1;
                shadow_len[sym] = (clen > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : clen;
                code_bits[sym]  = cw;
            end
            CMD_ENCODE: begin
                if (!code_valid[sym]) begin
                    // Unknown symbol: one marked result, state untouched.
                    r.data_byte  = '0;
                    r.valid_bits = '0;
                    r.unknown    = 1'b1;
                    r.total      = bits_sent;
                    bytes_due.push_back(r);
                end else begin
                    acc = {32'b0, pend_bits};
                    n   = pend_cnt;
                    // Code bits go out MSB first into the next free stream bit.
                    for (i = 0; i < shadow_len[sym]; i++) begin
                        acc[n] = code_bits[sym][WORD_W-1-i];
                        n++;
                    end
                    sum       = {1'b0, bits_sent} + 33'(shadow_len[sym]);
                    bits_sent = sum[32] ? '1 : sum[31:0];
                    nbytes    = n / 8;
                    for (i = 0; i < nbytes; i++) begin
                        r.data_byte  = acc[7:0];
                        r.valid_bits = FULL_BYTE_COUNT;
                        r.last       = (i == nbytes - 1);
                        r.total      = bits_sent;
                        bytes_due.push_back(r);
                        acc = acc >> 8;
                    end
                    pend_bits = acc[PEND_W-1:0];
                    pend_cnt  = PCNT_W'(n % 8);
                end
            end
            CMD_FLUSH: begin
                r.data_byte  = {1'b0, pend_bits};
                r.valid_bits = {1'b0, pend_cnt};
                r.total      = bits_sent;
                bytes_due.push_back(r);
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: begin
                // The unused command code is dropped without a result.
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch %0d at output transfer %0d: %s is 0x%0h, expected 0x%0h",
                     mismatches, n_out, what, got_v, want_v);
        end
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [WORD_W-1:0] cw, input logic [LEN_W-1:0] clen);
        cmd_backlog.push_back({clen, cw, sym, cmd});
        if (cmd == CMD_LOAD && !loaded_mask[sym]) begin
            loaded_mask[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // Mostly short codes so that many encodes leave no full byte, some long
    // ones, and a few lengths above the limit that the block must saturate.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(9);
        if (r < 7) begin
            return LEN_W'($urandom_range(12));
        end else if (r < 9) begin
            return LEN_W'($urandom_range(32, 13));
        end
        return LEN_W'($urandom_range(63, 33));
    endfunction

    // Random traffic that is mostly encodes, largely of loaded symbols, mixed
    // with loads, flushes, unknown symbols and the odd unused command.
    task automatic queue_random(input int count);
        int               roll;
        logic [SYM_W-1:0] sym;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                if (loaded_syms.size() != 0 && $urandom_range(3) == 0) begin
                    sym = SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
                end else begin
                    sym = SYM_W'($urandom_range(255));
                end
                queue_cmd(CMD_LOAD, sym, $urandom, pick_length());
            end else if (roll < 82) begin
                if (loaded_syms.size() != 0 && $urandom_range(9) != 0) begin
                    sym = SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
                end else begin
                    sym = SYM_W'($urandom_range(255));
                end
                queue_cmd(CMD_ENCODE, sym, $urandom, LEN_W'($urandom_range(63)));
            end else if (roll < 97) begin
                queue_cmd(CMD_FLUSH, SYM_W'($urandom_range(255)), $urandom,
                          LEN_W'($urandom_range(63)));
            end else begin
                queue_cmd(CMD_UNUSED, SYM_W'($urandom_range(255)), $urandom,
                          LEN_W'($urandom_range(63)));
            end
        end
    endtask

    // Returns once every command has been taken and every byte has arrived.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid || bytes_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            PH_SENDER_GAPS: return $urandom_range(99) < 66;
            PH_BOTH_GAPS:   return $urandom_range(99) < 6;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            PH_RECEIVER_STALLS: return $urandom_range(99) < 66;
            PH_BOTH_GAPS:       return $urandom_range(99) < 6;
            default:            return 1'b0;
        endcase
    endfunction

    // Command driver: a new command goes out on the falling edge once the
    // previous one has been taken; s_tvalid is written once per edge.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (cmd_backlog.size() != 0 && !sender_gap()) begin
                s_tdata  <= cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase. Entering the backpressure phase
    // starts a long hold-off, counted here, while the driver keeps offering
    // commands so that the internal queue fills and s_tready drops.
    always @(negedge aclk) begin
        if (idle_mode != ready_mode) begin
            ready_mode = idle_mode;
            hold_left  = (idle_mode == PH_BACKPRESSURE) ? HOLD_CYCLES : 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !receiver_stall();
        end
    end

    // Monitor and checker: everything is sampled on the rising edge. Each
    // accepted command feeds the predictor, and each output transfer is
    // compared field by field with the oldest byte still due.
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn) begin
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                pack_command(s_tdata);
                n_in++;
            end
            if (s_tvalid && !s_tready) begin
                n_backpressure++;
            end
            if (m_tvalid && m_tready) begin
                if (m_tdata[47:44] != '0) begin
                    report_mismatch("pad bits", 32'(m_tdata[47:44]), '0);
                end
                if (bytes_due.size() == 0) begin
                    report_mismatch("transfer with nothing due, out_byte",
                                    32'(m_tdata[7:0]), '0);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata[7:0] != want.data_byte) begin
                        report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data_byte));
                    end
                    if (m_tdata[11:8] != want.valid_bits) begin
                        report_mismatch("out_bit_count", 32'(m_tdata[11:8]),
                                        32'(want.valid_bits));
                    end
                    if (m_tlast != want.last) begin
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                    end
                    if (m_tuser != want.unknown) begin
                        report_mismatch("unknown_symbol", 32'(m_tuser), 32'(want.unknown));
                    end
                    if (m_tdata[43:12] != want.total) begin
                        report_mismatch("total_bits", m_tdata[43:12], want.total);
                    end
                    if (want.unknown) begin
                        n_unknown++;
                    end else if (want.valid_bits != FULL_BYTE_COUNT) begin
                        n_flush++;
                    end
                end
                n_out++;
            end
            // Watchdog: a long stretch with no transfer on either side is a hang.
            quiet = (s_taken || (m_tvalid && m_tready)) ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("no transfer for %0d cycles, %0d bytes still due",
                         quiet, bytes_due.size());
                $display("[huffman_table_encoder_bit_packer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands, no idling on either side.
        queue_cmd(CMD_ENCODE, 8'd0, '0, '0);                // empty table: unknown symbol
        queue_cmd(CMD_FLUSH, 8'd0, '0, '0);                 // flush with no bits pending
        queue_cmd(CMD_UNUSED, 8'hFF, '1, '1);               // ignored command
        queue_cmd(CMD_LOAD, 8'd0, '1, 6'd0);                // zero-length code is valid
        queue_cmd(CMD_ENCODE, 8'd0, '0, '0);                // appends nothing, no result
        queue_cmd(CMD_FLUSH, 8'd0, '0, '0);
        queue_cmd(CMD_LOAD, 8'hFF, '1, 6'd32);              // longest code, all ones
        queue_cmd(CMD_ENCODE, 8'hFF, '0, '0);               // four full bytes at once
        queue_cmd(CMD_LOAD, 8'd1, 32'hA000_0000, 6'd7);
        queue_cmd(CMD_ENCODE, 8'd1, '0, '0);                // seven bits, no byte yet
        queue_cmd(CMD_ENCODE, 8'hFF, '0, '0);               // 39 bits: four bytes, 7 left
        queue_cmd(CMD_ENCODE, 8'd77, '0, '0);               // unknown with bits pending
        queue_cmd(CMD_FLUSH, 8'd0, '0, '0);                 // seven-bit partial byte
        queue_cmd(CMD_LOAD, 8'd2, 32'h1234_5678, 6'd63);    // length clipped to 32
        queue_cmd(CMD_ENCODE, 8'd2, '0, '0);
        queue_cmd(CMD_LOAD, 8'd3, 32'hC000_0000, 6'd3);
        queue_cmd(CMD_ENCODE, 8'd3, '0, '0);
        queue_cmd(CMD_FLUSH, 8'd0, '0, '0);
        queue_cmd(CMD_LOAD, 8'd128, 32'h8000_0000, 6'd1);
        repeat (8) queue_cmd(CMD_ENCODE, 8'd128, '0, '0);   // single bits fill one byte
        queue_cmd(CMD_LOAD, 8'hFF, '0, 6'd5);               // overwrite an entry
        queue_cmd(CMD_ENCODE, 8'hFF, '0, '0);
        queue_cmd(CMD_FLUSH, 8'd0, '0, '0);
        wait_drained();

        idle_mode = PH_FREE;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // Long receiver hold-off against a steady stream of long codes.
        idle_mode = PH_BACKPRESSURE;
        queue_cmd(CMD_LOAD, 8'h5A, $urandom, 6'd32);
        queue_cmd(CMD_LOAD, 8'hA5, $urandom, 6'd29);
        repeat (24) begin
            queue_cmd(CMD_ENCODE, $urandom_range(1) ? 8'h5A : 8'hA5, $urandom,
                      LEN_W'($urandom_range(63)));
        end
        wait_drained();

        idle_mode = PH_SENDER_GAPS;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        idle_mode = PH_RECEIVER_STALLS;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        idle_mode = PH_BOTH_GAPS;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // Give any stray output a chance to show before judging the run.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands and checked %0d output transfers, %0d of them",
                 n_in, n_out, n_unknown + n_flush);
        $display("unknown-symbol or flush results; input was held off for %0d cycles.",
                 n_backpressure);
        if (mismatches == 0 && bytes_due.size() == 0) begin
            $display("[huffman_table_encoder_bit_packer] OK");
        end else begin
            $display("[huffman_table_encoder_bit_packer] ERROR");
        end
        $finish;
    end

endmodule
